// ===== src/ngcq_pkg.sv =====
// Shared widths, register codes, command and status types for the grid center quantizer.
package ngcq_pkg;

  // payload and register widths
  localparam int DATA_W     = 32;
  localparam int IDX_W      = 6;
  localparam int NUM_W      = 7;
  localparam int DIST_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // build arithmetic: Q1.30 positions, exact 33 bit span
  localparam int ACC_W      = 34;
  localparam int PROD_W     = 2 * ACC_W;
  localparam int DIV_STEPS  = 32;

  localparam int DEF_MAX_CENTERS = 64;

  localparam logic signed [ACC_W-1:0]  Q30_ONE      = ACC_W'(64'sd1 <<< 30);
  localparam logic [DATA_W-1:0]        POLY_NUMER   = 32'h8000_0000;  // 2^31
  localparam logic signed [DATA_W-1:0] SAT_POS      = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_NEG      = 32'sh8000_0000;

  // register reset values
  localparam logic [NUM_W-1:0]  NUM_RST  = 7'd3;
  localparam logic [DIST_W-1:0] DIST_RST = 2'd0;

  // distribution codes (code 3 builds as linear)
  localparam logic [DIST_W-1:0] DIST_LINEAR = 2'd0;
  localparam logic [DIST_W-1:0] DIST_CUBIC  = 2'd1;
  localparam logic [DIST_W-1:0] DIST_QUAD   = 2'd2;

  // query function codes
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_CENTERS  = 3'd0,
    REG_DISTRIBUTION = 3'd1,
    REG_RANGE_MIN    = 3'd2,
    REG_RANGE_MAX    = 3'd3,
    REG_VALUE_OFFSET = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MUL_SQ   = 2'd0,
    MUL_CUBE = 2'd1,
    MUL_MAP  = 2'd2
  } mul_op_e;

  // controller -> datapath
  typedef struct packed {
    logic    build_init;
    logic    load_step;
    logic    mul_en;
    mul_op_e mul_op;
    logic    tbl_wr;
    logic    capture;
    logic    scan_rd;
    logic    dec_rd;
    logic    load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic poly;
    logic cubic;
    logic build_last;
    logic scan_last;
    logic cfg_hit;
  } sts_t;

endpackage

// ===== src/ngcq_if.sv =====
// Query and result channel interfaces.
interface ngcq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic signed [ngcq_pkg::DATA_W-1:0]   sample_value;
  logic        [ngcq_pkg::IDX_W-1:0]    feature_index;

  modport source (output valid, func, sample_value, feature_index, input ready);
  modport sink   (input valid, func, sample_value, feature_index, output ready);
endinterface

interface ngcq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ngcq_pkg::IDX_W-1:0]    nearest_index;
  logic signed [ngcq_pkg::DATA_W-1:0]   center_value;
  logic                                 bad_index;

  modport source (output valid, nearest_index, center_value, bad_index, input ready);
  modport sink   (input valid, nearest_index, center_value, bad_index, output ready);
endinterface

// ===== src/ngcq_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ngcq_div #(
  parameter int DVW = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ngcq_pkg::DATA_W-1:0]   dividend_i,
  input  logic [DVW-1:0]                divisor_i,
  output logic [ngcq_pkg::DATA_W-1:0]   quotient_o,
  output logic [DVW-1:0]                remainder_o,
  output logic                          done_o
);
  import ngcq_pkg::*;

  localparam int CntW = $clog2(DIV_STEPS + 1);

  logic [CntW-1:0]   cnt_q;
  logic              done_q;
  logic [DATA_W-1:0] quo_q;
  logic [DVW-1:0]    rem_q;
  logic [DVW-1:0]    div_q;
  logic [DVW:0]      rem_sh;
  logic              fits;
  logic [DVW-1:0]    rem_nx;

  always_comb begin
    rem_sh = {rem_q, quo_q[DATA_W-1]};
    fits   = rem_sh >= {1'b0, div_q};
    rem_nx = fits ? DVW'(rem_sh - {1'b0, div_q}) : DVW'(rem_sh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(DIV_STEPS);
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CntW'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DATA_W-2:0], fits};
      rem_q <= rem_nx;
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

endmodule

// ===== src/ngcq_dp.sv =====
// Datapath: config registers, center builder, center memory, nearest search.
module ngcq_dp #(
  parameter int MAX_CENTERS = ngcq_pkg::DEF_MAX_CENTERS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ngcq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ngcq_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_func_i,
  input  logic signed [ngcq_pkg::DATA_W-1:0]  in_sample_i,
  input  logic [ngcq_pkg::IDX_W-1:0]          in_fidx_i,
  input  ngcq_pkg::cmd_t                      cmd_i,
  output ngcq_pkg::sts_t                      sts_o,
  output logic [ngcq_pkg::IDX_W-1:0]          out_nearest_o,
  output logic signed [ngcq_pkg::DATA_W-1:0]  out_center_o,
  output logic                                out_bad_o
);
  import ngcq_pkg::*;

  localparam int AW   = $clog2(MAX_CENTERS);
  localparam int CW   = $clog2(MAX_CENTERS + 1);
  localparam int NW   = (CW > NUM_W) ? CW : NUM_W;
  localparam int CmpW = (CW > IDX_W) ? CW : IDX_W;

  // configuration
  logic [NUM_W-1:0]         num_q;
  logic [DIST_W-1:0]        dist_q;
  logic signed [DATA_W-1:0] min_q;
  logic signed [DATA_W-1:0] max_q;
  logic signed [DATA_W-1:0] offset_q;
  logic                     cfg_hit;

  // derived config
  logic [NW-1:0]            num_ext;
  logic [CW-1:0]            n_act;
  logic [CW-1:0]            n_last;
  logic                     poly;
  logic                     cubic;
  logic signed [DATA_W:0]   span;
  logic                     span_neg;
  logic [DATA_W:0]          span_abs;

  // divider hookup
  logic [DATA_W-1:0]        div_dividend;
  logic [CW-1:0]            div_divisor;
  logic [DATA_W-1:0]        div_quo;
  logic [CW-1:0]            div_rem;
  logic                     div_done;

  // builder
  logic [AW-1:0]            bi_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [DATA_W:0]   step_q;
  logic [CW-1:0]            stepr_q;
  logic [CW-1:0]            rem_q;
  logic [CW-1:0]            d_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [CW:0]              rem_sum;
  logic                     wrap;
  logic [CW-1:0]            rem_nx;
  logic signed [ACC_W-1:0]  acc_nx;
  logic signed [ACC_W-1:0]  q_sh;
  logic signed [ACC_W-1:0]  mul_a;
  logic signed [ACC_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_d;
  logic [DATA_W-1:0]        center_wr;

  // memory and search
  logic [DATA_W-1:0]        mem [MAX_CENTERS];
  logic [DATA_W-1:0]        rdata_q;
  logic                     rd_en;
  logic [AW-1:0]            raddr;
  logic                     rd_vld_q;
  logic [AW-1:0]            rd_idx_q;
  logic [AW-1:0]            si_q;
  logic                     func_q;
  logic signed [DATA_W-1:0] v_q;
  logic [IDX_W-1:0]         fidx_q;
  logic [DATA_W:0]          in_sum;
  logic signed [DATA_W-1:0] v_sat;
  logic [DATA_W:0]          diff;
  logic [DATA_W:0]          absd;
  logic                     take;
  logic [DATA_W:0]          best_d_q;
  logic [AW-1:0]            best_i_q;
  logic [DATA_W-1:0]        best_c_q;
  logic                     bad;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q    <= NUM_RST;
      dist_q   <= DIST_RST;
      min_q    <= '0;
      max_q    <= '0;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NUM_CENTERS:  num_q    <= cfg_data_i[NUM_W-1:0];
        REG_DISTRIBUTION: dist_q   <= cfg_data_i[DIST_W-1:0];
        REG_RANGE_MIN:    min_q    <= $signed(cfg_data_i);
        REG_RANGE_MAX:    max_q    <= $signed(cfg_data_i);
        REG_VALUE_OFFSET: offset_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx_i)
      REG_NUM_CENTERS, REG_DISTRIBUTION, REG_RANGE_MIN, REG_RANGE_MAX,
      REG_VALUE_OFFSET: cfg_hit = cfg_we_i;
      default:          cfg_hit = 1'b0;
    endcase
  end

  // center count clamped to [2, MAX_CENTERS]
  always_comb begin
    num_ext = NW'(num_q);
    if (num_ext < NW'(2)) begin
      n_act = CW'(2);
    end else if (num_ext > NW'(MAX_CENTERS)) begin
      n_act = CW'(MAX_CENTERS);
    end else begin
      n_act = CW'(num_ext);
    end
  end

  assign n_last   = n_act - CW'(1);
  assign poly     = (dist_q == DIST_CUBIC) || (dist_q == DIST_QUAD);
  assign cubic    = (dist_q == DIST_CUBIC);
  assign span     = $signed({max_q[DATA_W-1], max_q}) - $signed({min_q[DATA_W-1], min_q});
  assign span_neg = span[DATA_W];
  assign span_abs = span_neg ? DATA_W'(0) - span : span;

  // linear: span / (n-1); curved: 2^31 / n
  assign div_dividend = poly ? POLY_NUMER : span_abs[DATA_W-1:0];
  assign div_divisor  = poly ? n_act : n_last;

  ngcq_div #(.DVW(CW)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.build_init),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .done_o      (div_done)
  );

  // ---------------- builder arithmetic ----------------
  // acc = i*step + floor(i*stepr/d), advanced with one compare/subtract
  always_comb begin
    rem_sum = {1'b0, rem_q} + {1'b0, stepr_q};
    wrap    = rem_sum >= {1'b0, d_q};
    rem_nx  = wrap ? CW'(rem_sum - {1'b0, d_q}) : CW'(rem_sum);
    acc_nx  = acc_q + {step_q[DATA_W], step_q} + {{(ACC_W-1){1'b0}}, wrap};
  end

  assign q_sh = $signed(prod_q[ACC_W+29:30]);  // floor(prod / 2^30)

  always_comb begin
    mul_a = acc_q;
    mul_b = acc_q;
    case (cmd_i.mul_op)
      MUL_SQ: begin
        mul_a = acc_q;
        mul_b = acc_q;
      end
      MUL_CUBE: begin
        mul_a = q_sh;
        mul_b = acc_q;
      end
      MUL_MAP: begin
        mul_a = q_sh + Q30_ONE;
        mul_b = $signed({span[DATA_W], span});
      end
      default: ;
    endcase
    prod_d = mul_a * mul_b;
  end

  // mapped offset is floor(prod / 2^31); its low word suffices since the center fits
  assign center_wr = poly ? DATA_W'(min_q + $signed(prod_q[DATA_W+30:31]))
                          : DATA_W'(min_q + $signed(acc_q[DATA_W-1:0]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.build_init) begin
      bi_q  <= '0;
      rem_q <= '0;
      d_q   <= div_divisor;
      acc_q <= poly ? -Q30_ONE : '0;
    end else if (cmd_i.tbl_wr) begin
      bi_q  <= bi_q + AW'(1);
      rem_q <= rem_nx;
      acc_q <= acc_nx;
    end
    if (cmd_i.load_step) begin
      if (!poly && span_neg) begin
        if (div_rem != '0) begin
          step_q  <= -$signed({1'b0, div_quo}) - $signed({{DATA_W{1'b0}}, 1'b1});
          stepr_q <= d_q - div_rem;
        end else begin
          step_q  <= -$signed({1'b0, div_quo});
          stepr_q <= '0;
        end
      end else begin
        step_q  <= $signed({1'b0, div_quo});
        stepr_q <= div_rem;
      end
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // ---------------- center memory ----------------
  assign rd_en = cmd_i.scan_rd || cmd_i.dec_rd;
  assign raddr = cmd_i.scan_rd ? si_q : AW'(fidx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr) begin
      mem[bi_q] <= center_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // ---------------- query ----------------
  always_comb begin
    in_sum = {in_sample_i[DATA_W-1], in_sample_i} + {offset_q[DATA_W-1], offset_q};
    if (in_sum[DATA_W] != in_sum[DATA_W-1]) begin
      v_sat = in_sum[DATA_W] ? SAT_NEG : SAT_POS;
    end else begin
      v_sat = $signed(in_sum[DATA_W-1:0]);
    end
    diff = {v_q[DATA_W-1], v_q} - {rdata_q[DATA_W-1], rdata_q};
    absd = diff[DATA_W] ? (DATA_W+1)'(0) - diff : diff;
    // strict compare keeps the lowest index on a tie
    take = rd_vld_q && ((rd_idx_q == '0) || (absd < best_d_q));
    bad  = !(CmpW'(fidx_q) < CmpW'(n_act));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= in_func_i;
      v_q    <= v_sat;
      fidx_q <= in_fidx_i;
      si_q   <= '0;
    end else if (cmd_i.scan_rd) begin
      si_q <= si_q + AW'(1);
    end
    if (cmd_i.scan_rd) begin
      rd_idx_q <= si_q;
    end
    if (take) begin
      best_d_q <= absd;
      best_i_q <= rd_idx_q;
      best_c_q <= rdata_q;
    end
    if (cmd_i.load_out) begin
      if (func_q == FUNC_DECODE) begin
        out_nearest_o <= fidx_q;
        out_center_o  <= bad ? '0 : $signed(rdata_q);
        out_bad_o     <= bad;
      end else begin
        out_nearest_o <= IDX_W'(best_i_q);
        out_center_o  <= $signed(best_c_q);
        out_bad_o     <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.div_done   = div_done;
    sts_o.poly       = poly;
    sts_o.cubic      = cubic;
    sts_o.build_last = (CW'(bi_q) == n_last);
    sts_o.scan_last  = (CW'(si_q) == n_last);
    sts_o.cfg_hit    = cfg_hit;
  end

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_rd |-> (CW'(si_q) < n_act))
    else $error("scan address past center count");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tbl_wr |-> (CW'(bi_q) < n_act))
    else $error("builder write past center count");

endmodule

// ===== src/ngcq_ctrl.sv =====
// Controller: sequences table build, encode scan, decode read and result hand-off.
module ngcq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_func_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  input  ngcq_pkg::sts_t  sts_i,
  output ngcq_pkg::cmd_t  cmd_o
);
  import ngcq_pkg::*;

  typedef enum logic [3:0] {
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SQ,
    ST_CUBE,
    ST_MAP,
    ST_WRITE,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DEC,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_ready;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_op  = MUL_SQ;
    in_ready      = 1'b0;
    case (state_q)
      ST_DIV_START: begin
        cmd_o.build_init = 1'b1;
        state_d          = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.load_step = 1'b1;
          state_d         = sts_i.poly ? ST_SQ : ST_WRITE;
        end
      end
      ST_SQ: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_SQ;
        state_d      = sts_i.cubic ? ST_CUBE : ST_MAP;
      end
      ST_CUBE: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_CUBE;
        state_d      = ST_MAP;
      end
      ST_MAP: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_MAP;
        state_d      = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.tbl_wr = 1'b1;
        if (sts_i.build_last) begin
          state_d = ST_IDLE;
        end else begin
          state_d = sts_i.poly ? ST_SQ : ST_WRITE;
        end
      end
      ST_IDLE: begin
        in_ready = !sts_i.cfg_hit;
        if (in_valid_i && !sts_i.cfg_hit) begin
          cmd_o.capture = 1'b1;
          state_d       = (in_func_i == FUNC_DECODE) ? ST_DEC : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_d = ST_RESULT;
      end
      ST_DEC: begin
        cmd_o.dec_rd = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_DIV_START;
    endcase
    // any register write restarts the build
    if (sts_i.cfg_hit) begin
      state_d = ST_DIV_START;
    end
    out_valid_d = cmd_o.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_DIV_START;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;

  a_no_stale_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !sts_i.div_done)
    else $error("divider finished while controller idle");

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready) |=> !in_ready)
    else $error("second query taken while one is in flight");

endmodule

// ===== src/nearest_grid_center_quantizer.sv =====
// Top level of the nearest grid center quantizer.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+---------------------------------------------
//  in_ch    | in  | valid/ready       | func, sample_value (Q16.16), feature_index
//  out_ch   | out | valid/ready       | nearest_index, center_value (Q16.16), bad_index
//  cfg      | in  | cfg_we_i, no wait | cfg_idx_i selects register, cfg_data_i
//
// Encode: the scan reads all n centers (n = clamped center count), one center per cycle through
//   the memory read port, before the result is loaded and the next query can be taken.
// Decode: one memory read.
// Build after reset or a register write: divider (one bit per cycle), then per center a write
//   after square, map (quadratic) or square, cube, map (cubic); in_ch.ready is low meanwhile.
//   After reset the build covers the 3 reset centers, so the table needs no clearing pass.
// A finished result sits in the output register; the next query is taken while it waits.
module nearest_grid_center_quantizer #(
  parameter int MAX_CENTERS = ngcq_pkg::DEF_MAX_CENTERS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ngcq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ngcq_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ngcq_in_if.sink                           in_ch,
  ngcq_out_if.source                        out_ch
);
  import ngcq_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  // Datapath: config registers, divider, multiplier, center memory, search.
  ngcq_dp #(.MAX_CENTERS(MAX_CENTERS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_func_i     (in_ch.func),
    .in_sample_i   (in_ch.sample_value),
    .in_fidx_i     (in_ch.feature_index),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_nearest_o (out_ch.nearest_index),
    .out_center_o  (out_ch.center_value),
    .out_bad_o     (out_ch.bad_index)
  );

  // Controller: build sequence, query sequence, output register valid.
  ngcq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_func_i   (in_ch.func),
    .in_ready_o  (in_ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
